// File: hw/rtl/drp_pkg.sv
// ----------------------------------------------------------------------------
// drp_pkg
// Shared types and constants for the dead-reckoning pose update block:
// sequencer states, register indexes, CORDIC gain and arctangent table.
// ----------------------------------------------------------------------------
package drp_pkg;

  localparam int DefCordicSteps = 16;
  localparam int DefAngleBits   = 16;

  // Configuration register indexes.
  localparam logic [1:0] REG_START_X       = 2'd0;
  localparam logic [1:0] REG_START_Y       = 2'd1;
  localparam logic [1:0] REG_START_HEADING = 2'd2;

  // CORDIC gain 0.60725293500888 in Q2.30.
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // atan(2^-i) in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_ROTATE,
    S_MUL_X,
    S_MUL_Y,
    S_ACC_Y,
    S_FINISH
  } drp_state_t;

endpackage

// File: hw/rtl/dead_reckoning_pose_update_top.sv
// Takes one input item at a time: s_tready is high only in the idle state. Each item
// runs through setup, the shared CORDIC add/shift unit doing one rotation per cycle,
// then one shared multiplier used for x and for y, and a finish step that loads the
// result. An input item may be taken while a result still waits.
// Reset (rst, synchronous): pose and start registers clear to zero, sequencer idle.
// ----------------------------------------------------------------------------
// dead_reckoning_pose_update_top
// Integrates turn/travel orders into an x, y, heading pose using an iterative
// CORDIC for sine and cosine and saturating Q16.16 position updates.
// ----------------------------------------------------------------------------
module dead_reckoning_pose_update_top
  import drp_pkg::*;
#(
  parameter int CORDIC_STEPS = DefCordicSteps,
  parameter int ANGLE_BITS   = DefAngleBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // turn_angle[15:0], travel_length[47:16]
  input  logic        s_tuser,   // restart
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata    // pose_x[31:0], pose_y[63:32], pose_heading[79:64]
);

  localparam int NITER = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
  localparam logic [4:0] ITER_LAST = 5'(NITER - 1);
  localparam int ASHIFT = 32 - ANGLE_BITS;

  drp_state_t state, state_next;

  logic signed [31:0]    start_x, start_y;
  logic [ANGLE_BITS-1:0] start_heading;
  logic signed [31:0]    cur_x, cur_y;
  logic [ANGLE_BITS-1:0] cur_heading;
  logic signed [31:0]    len;

  logic signed [33:0] cx, cy, cz;
  logic [4:0]         iter;
  logic signed [65:0] prod;

  logic [79:0] out_data;

  logic                  s_fire;
  logic                  out_load;
  logic                  mul_sel_y;
  logic [31:0]           turn_ext, cfg_head_ext;
  logic [ANGLE_BITS-1:0] base_heading;
  logic [31:0]           angle, angle_fold;
  logic                  fold;
  logic signed [33:0]    dx, dy, atan_step;
  logic signed [33:0]    mul_b;
  logic signed [65:0]    mul_out;
  logic signed [65:0]    rnd_full;
  logic signed [35:0]    acc_sum;
  logic signed [31:0]    acc_pos, acc_sat;
  logic [31:0]           head_ext;

  assign s_fire = s_tvalid && s_tready;

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (s_fire) state_next = S_SETUP;
      S_SETUP:  state_next = S_ROTATE;
      S_ROTATE: if (iter == ITER_LAST) state_next = S_MUL_X;
      S_MUL_X:  state_next = S_MUL_Y;
      S_MUL_Y:  state_next = S_ACC_Y;
      S_ACC_Y:  state_next = S_FINISH;
      S_FINISH: if (!m_tvalid || m_tready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    s_tready  = 1'b0;
    mul_sel_y = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      S_IDLE:   s_tready = 1'b1;
      S_MUL_Y:  mul_sel_y = 1'b1;
      S_FINISH: out_load = !m_tvalid || m_tready;
      default:  ;
    endcase
  end

  // Heading accumulation on accept.
  always_comb begin
    turn_ext     = {16'd0, s_tdata[15:0]};
    base_heading = s_tuser ? start_heading : cur_heading;
  end

  assign cfg_head_ext = {16'd0, cfg_wdata[15:0]};

  // Quadrant fold into [-1/4, 1/4) turn.
  always_comb begin
    angle      = 32'(cur_heading) << ASHIFT;
    fold       = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
    angle_fold = fold ? (angle ^ 32'h80000000) : angle;
  end

  // Shared CORDIC add/shift unit.
  always_comb begin
    dx        = cy >>> iter;
    dy        = cx >>> iter;
    atan_step = $signed({2'b00, ATAN_TURNS[iter]});
  end

  // Shared multiplier and saturating accumulate.
  always_comb begin
    mul_b    = mul_sel_y ? cy : cx;
    mul_out  = 66'(len) * 66'(mul_b);
    rnd_full = (prod + 66'sd536870912) >>> 30;
    acc_pos  = (state == S_ACC_Y) ? cur_y : cur_x;
    acc_sum  = 36'(acc_pos) + rnd_full[35:0];
    if (acc_sum > 36'sd2147483647) begin
      acc_sat = 32'sh7FFFFFFF;
    end else if (acc_sum < -36'sd2147483648) begin
      acc_sat = 32'sh80000000;
    end else begin
      acc_sat = acc_sum[31:0];
    end
  end

  assign head_ext = 32'(cur_heading);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      start_x       <= '0;
      start_y       <= '0;
      start_heading <= '0;
      cur_x         <= '0;
      cur_y         <= '0;
      cur_heading   <= '0;
      m_tvalid      <= 1'b0;
      iter          <= '0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (cfg_addr)
          REG_START_X:       start_x <= cfg_wdata;
          REG_START_Y:       start_y <= cfg_wdata;
          REG_START_HEADING: start_heading <= cfg_head_ext[ANGLE_BITS-1:0];
          default:           ;
        endcase
      end

      if (s_fire) begin
        if (s_tuser) begin
          cur_x <= start_x;
          cur_y <= start_y;
        end
        cur_heading <= base_heading + turn_ext[ANGLE_BITS-1:0];
      end

      if (state == S_SETUP) begin
        iter <= '0;
      end else if (state == S_ROTATE) begin
        iter <= iter + 5'd1;
      end

      // Product from the x multiply is accumulated while y multiplies.
      if (state == S_MUL_Y) cur_x <= acc_sat;
      if (state == S_ACC_Y) cur_y <= acc_sat;

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (s_fire) len <= s_tdata[47:16];
    if (state == S_SETUP) begin
      cx <= fold ? -CORDIC_GAIN : CORDIC_GAIN;
      cy <= '0;
      cz <= 34'($signed(angle_fold));
    end else if (state == S_ROTATE) begin
      if (!cz[33]) begin
        cx <= cx - dx;
        cy <= cy + dy;
        cz <= cz - atan_step;
      end else begin
        cx <= cx + dx;
        cy <= cy - dy;
        cz <= cz + atan_step;
      end
    end
    if (state == S_MUL_X || state == S_MUL_Y) prod <= mul_out;
    if (out_load) out_data <= {head_ext[15:0], cur_y, cur_x};
  end

  assign m_tdata = out_data;

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: dead-reckoning pose update testbench
// Drives turn/travel orders into the block, keeps its own fixed-point model
// of the pose (CORDIC sine/cosine, rounded Q16.16 steps, saturating sums) and
// checks every pose it returns, under several mixes of sender gaps and
// receiver stalls, start-pose settings and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import drp_pkg::*;

  localparam int CordicSteps   = DefCordicSteps;
  localparam int AngleBits     = DefAngleBits;
  localparam longint GainQ30   = 652032874;
  localparam int WatchdogLimit = 3000;
  localparam logic [1:0] RegUnused = 2'd3;

  // Arctangent of 2^-i in 2^-32 turn units.
  localparam logic [31:0] AtanTbl [32] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
  };

  typedef struct packed {
    logic [15:0]        heading;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } pose_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [31:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // turn_angle[15:0], travel_length[47:16]
  logic        s_tuser;   // restart
  logic        m_tvalid;
  logic        m_tready;
  logic [79:0] m_tdata;   // pose_x[31:0], pose_y[63:32], pose_heading[79:64]

  // Predicted pose and start registers.
  logic signed [31:0]     pos_x, pos_y, home_x, home_y;
  logic [AngleBits-1:0]   head_now, home_heading;

  pose_t expected_poses [$];
  int    mismatches;
  int    send_idle_pct;
  int    stall_pct;
  int    hold_req;
  int    idle_cycles;

  dead_reckoning_pose_update_top #(
    .CORDIC_STEPS(CordicSteps),
    .ANGLE_BITS  (AngleBits)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  function automatic void cordic_trig(input logic [AngleBits-1:0] hd,
                                      output longint cosv, output longint sinv);
    logic [31:0] ang;
    longint cx, sy, z, dx, dy;
    ang = 32'(hd) << (32 - AngleBits);
    cx  = GainQ30;
    sy  = 0;
    // Fold the second and third quadrants onto the first and fourth.
    if (ang[31:30] == 2'd1 || ang[31:30] == 2'd2) begin
      ang = ang - 32'h8000_0000;
      cx  = -cx;
    end
    z = longint'(signed'(ang));
    for (int i = 0; i < CordicSteps && i < 32; i++) begin
      dx = sy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx = cx - dx;
        sy = sy + dy;
        z  = z - longint'(AtanTbl[i]);
      end else begin
        cx = cx + dx;
        sy = sy - dy;
        z  = z + longint'(AtanTbl[i]);
      end
    end
    cosv = cx;
    sinv = sy;
  endfunction

  function automatic logic signed [31:0] move_axis(input logic signed [31:0] pos,
                                                  input logic signed [31:0] len,
                                                  input longint trig);
    longint delta, total;
    delta = (longint'(len) * trig + (longint'(1) << 29)) >>> 30;
    total = longint'(pos) + delta;
    if (total > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (total < -64'sd2147483648) return 32'sh8000_0000;
    return total[31:0];
  endfunction

  function automatic pose_t integrate_order(input logic [15:0] turn,
                                            input logic signed [31:0] len,
                                            input logic restart);
    longint cosv, sinv;
    pose_t  p;
    if (restart) begin
      pos_x    = home_x;
      pos_y    = home_y;
      head_now = home_heading;
    end
    head_now = head_now + AngleBits'(turn);
    cordic_trig(head_now, cosv, sinv);
    pos_x = move_axis(pos_x, len, cosv);
    pos_y = move_axis(pos_y, len, sinv);
    p.x       = pos_x;
    p.y       = pos_y;
    p.heading = 16'(head_now);
    return p;
  endfunction

  // --------------------------------------------------------------- drivers

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_START_X:       home_x = value;
      REG_START_Y:       home_y = value;
      REG_START_HEADING: home_heading = AngleBits'(value[15:0]);
      default: ;
    endcase
  endtask

  task automatic load_start_pose(input logic [31:0] sx, input logic [31:0] sy,
                                 input logic [31:0] sh);
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_START_HEADING, sh);
  endtask

  // Leaves tvalid high on return so that back-to-back items need no gap.
  task automatic send_order(input logic [15:0] turn, input logic [31:0] len,
                            input logic restart);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 30);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {len, turn};
    s_tuser  <= restart;
    do @(posedge clk); while (!s_tready);
    expected_poses = {expected_poses, integrate_order(turn, len, restart)};
  endtask

  task automatic drain_orders();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_length();
    int sel;
    logic [31:0] v;
    sel = $urandom_range(99);
    v   = $urandom;
    if (sel < 60) v = {{12{v[19]}}, v[19:0]};
    else if (sel < 85) v = {{6{v[25]}}, v[25:0]};
    else if (sel >= 95) begin
      case ($urandom_range(2))
        0: v = 32'h7FFF_FFFF;
        1: v = 32'h8000_0000;
        default: v = 32'h0;
      endcase
    end
    return v;
  endfunction

  // Receiver: random stalls, plus a long hold-off counted here on request.
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------- checker

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (mismatches < 40)
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    pose_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = pose_t'(m_tdata);
      if (expected_poses.size() == 0) begin
        if (mismatches < 40)
          $display("%0t: pose with no pending order, expected none, actual %h %h %h",
                   $time, got.x, got.y, got.heading);
        mismatches++;
      end else begin
        want = expected_poses.pop_front();
        if (got.x !== want.x) note_mismatch("pose_x", want.x, got.x);
        if (got.y !== want.y) note_mismatch("pose_y", want.y, got.y);
        if (got.heading !== want.heading)
          note_mismatch("pose_heading", 32'(want.heading), 32'(got.heading));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no item moved for %0d cycles", $time, WatchdogLimit);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ------------------------------------------------------------------ tests

  // Quadrant edges, length extremes, rounding of tiny steps and saturation
  // in both directions, starting from the reset pose.
  task automatic test_directed_orders();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_order(16'h0000, 32'h0000_0000, 1'b0);
    send_order(16'h0000, 32'h0001_0000, 1'b0);
    send_order(16'h4000, 32'h0001_0000, 1'b0);
    send_order(16'h4000, 32'h0001_0000, 1'b0);
    send_order(16'h4000, 32'h0001_0000, 1'b0);
    send_order(16'h3FFF, 32'h0001_0000, 1'b0);
    send_order(16'hFFFF, 32'h7FFF_FFFF, 1'b1);
    send_order(16'h0001, 32'h7FFF_FFFF, 1'b0);
    send_order(16'h8000, 32'h7FFF_FFFF, 1'b0);
    send_order(16'h0000, 32'h8000_0000, 1'b0);
    send_order(16'h0000, 32'h8000_0000, 1'b1);
    send_order(16'h0000, 32'h8000_0000, 1'b0);
    send_order(16'h2000, 32'hFFFF_FFFF, 1'b1);
    send_order(16'hBFFF, 32'h0000_0001, 1'b0);
    send_order(16'h4001, 32'h0001_8000, 1'b0);
    send_order(16'h5555, 32'h0000_8000, 1'b0);
    drain_orders();
  endtask

  // Extreme start poses, an ignored write to the spare index, and upper
  // write-data bits that the heading register must drop.
  task automatic test_start_registers();
    load_start_pose(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_FFFF);
    write_reg(RegUnused, 32'hDEAD_BEEF);
    send_order(16'h0000, 32'h7FFF_FFFF, 1'b1);
    send_order(16'h0001, 32'h8000_0000, 1'b1);
    send_order(16'h4000, 32'h0010_0000, 1'b0);
    drain_orders();
    load_start_pose(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_8000);
    send_order(16'h0000, 32'h0000_0000, 1'b1);
    send_order(16'hC000, 32'h7FFF_FFFF, 1'b1);
    drain_orders();
    load_start_pose(32'h0, 32'h0, 32'h0);
    send_order(16'h1234, 32'h0003_0000, 1'b1);
    drain_orders();
  endtask

  task automatic test_random_traffic(input int count, input int idle, input int stall);
    logic [15:0] turn;
    load_start_pose($urandom, $urandom, $urandom);
    send_idle_pct = idle;
    stall_pct     = stall;
    repeat (count) begin
      turn = ($urandom_range(9) == 0) ? 16'($urandom_range(3) << 14) : 16'($urandom);
      send_order(turn, rand_length(), $urandom_range(24) == 0);
    end
    drain_orders();
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 300;
    repeat (60) send_order(16'($urandom), rand_length(), $urandom_range(24) == 0);
    drain_orders();
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_addr      = REG_START_X;
    cfg_wdata     = '0;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = 1'b0;
    mismatches    = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 0;
    idle_cycles   = 0;
    pos_x         = '0;
    pos_y         = '0;
    head_now      = '0;
    home_x        = '0;
    home_y        = '0;
    home_heading  = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_directed_orders();
    test_start_registers();
    test_random_traffic(460, 0, 0);
    test_random_traffic(460, 46, 0);
    test_random_traffic(460, 0, 46);
    test_random_traffic(460, 21, 21);
    test_output_backpressure();

    repeat (30) @(posedge clk);
    if (expected_poses.size() != 0) begin
      $display("%0t: %0d poses never arrived", $time, expected_poses.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/drp_pkg.sv
hw/rtl/dead_reckoning_pose_update_top.sv
tb/tb_top.sv
